// ===== rtl/pfe_pkg.sv =====
// shared types, constants and helpers of the printf format engine
package pfe_pkg;

	localparam int MAX_WIDTH = 32;
	localparam int FW_W      = $clog2(MAX_WIDTH + 1);
	localparam int NUM_DEC   = 20;
	localparam int NUM_HEX   = 16;
	localparam int ARG_W     = 64;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_UA    = 8'h41;

	typedef enum logic [1:0] {
		ST_PLAIN,
		ST_PERCENT,
		ST_WIDTH,
		ST_SIZE
	} parse_state_t;

	typedef enum logic [2:0] {
		SZ_NORMAL,
		SZ_HH,
		SZ_H,
		SZ_L,
		SZ_LL
	} size_code_t;

	typedef enum logic [2:0] {
		JK_ECHO,
		JK_PAD,
		JK_CHAR,
		JK_DEC,
		JK_HEX
	} job_kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CONV,
		BK_STRIP,
		BK_EMIT
	} back_state_t;

	typedef struct packed {
		logic             mode;
		logic [7:0]       in_byte;
		logic [ARG_W-1:0] arg_value;
	} item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
	} result_t;

	// width holds the pad count for pad and char jobs
	typedef struct packed {
		job_kind_t        kind;
		logic [7:0]       ch;
		logic [ARG_W-1:0] value;
		logic             neg;
		logic             upper;
		logic             zpad;
		logic [FW_W-1:0]  width;
	} job_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base;
		base = upper ? CH_UA : CH_LA;
		if (d < 4'd10)
			digit_char = CH_ZERO + {4'd0, d};
		else
			digit_char = base + {4'd0, d} - 8'd10;
	endfunction

endpackage

// ===== rtl/printf_format_engine_core.sv =====
// top level of the printf subset formatter
//
//   beat     | ports                 | handshake
//   ---------+-----------------------+--------------------------
//   item     | item (item_t)         | push, full
//   result   | result (result_t)     | pop, empty
//
// an echoed byte passes the job queue and the formatter to the output register; a %d
// spec leaves the queue, runs a shift-add conversion over 64 bits, then leading-zero
// strip over 20 digits and pad setup, then emits its characters; %x skips
// the conversion and strips over 16 digits. the parser takes an item every
// cycle while the two-entry job queue has room; the formatter runs one job at a time
// and holds while a result waits for pop.
// reset clears the parse state, the queue count, the formatter state and the output valid flag.
module printf_format_engine_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  pfe_pkg::item_t   item,
	input  logic             pop,
	output logic             empty,
	output pfe_pkg::result_t result
);
	import pfe_pkg::*;

	logic    accept, job_valid, job_take, q_empty, res_valid;
	job_t    job_in, job_out;

	assign accept = push && !full;
	assign empty  = !res_valid;

	pfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.job_valid (job_valid),
		.job       (job_in)
	);

	pfe_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_valid),
		.wdata  (job_in),
		.rd     (job_take),
		.rdata  (job_out),
		.full   (full),
		.empty  (q_empty)
	);

	pfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_avail (!q_empty),
		.job       (job_out),
		.job_take  (job_take),
		.pop       (pop),
		.res_valid (res_valid),
		.result    (result)
	);
endmodule

// ===== rtl/pfe_fifo.sv =====
// two-entry job queue between the parser and the formatter
module pfe_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  pfe_pkg::job_t wdata,
	input  logic          rd,
	output pfe_pkg::job_t rdata,
	output logic          full,
	output logic          empty
);
	import pfe_pkg::*;

	job_t       mem [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (wr)
				wptr_q <= ~wptr_q;
			if (rd)
				rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule

// ===== rtl/pfe_front.sv =====
// format parser: tracks the spec and turns bytes into formatting jobs
module pfe_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  pfe_pkg::item_t item,
	output logic           job_valid,
	output pfe_pkg::job_t  job
);
	import pfe_pkg::*;

	parse_state_t    st_q, st_d;
	logic            zpad_q, zpad_d;
	logic [FW_W-1:0] fw_q, fw_d;
	size_code_t      sz_q, sz_d;

	logic [7:0]       b;
	logic [3:0]       dig;
	logic [FW_W+3:0]  wsum;
	logic [ARG_W-1:0] mask, mag;
	logic             sbit;

	assign b   = item.in_byte;
	assign dig = b[3:0];
	assign wsum = (FW_W+4)'(fw_q) * (FW_W+4)'(10) + (FW_W+4)'(dig);

	always_comb begin
		unique case (sz_q)
			SZ_HH: begin
				mask = 64'h0000_0000_0000_00FF;
				sbit = item.arg_value[7];
			end
			SZ_H: begin
				mask = 64'h0000_0000_0000_FFFF;
				sbit = item.arg_value[15];
			end
			SZ_L, SZ_LL: begin
				mask = '1;
				sbit = item.arg_value[63];
			end
			default: begin
				mask = 64'h0000_0000_FFFF_FFFF;
				sbit = item.arg_value[31];
			end
		endcase
		mag = item.arg_value & mask;
	end

	always_comb begin
		st_d      = st_q;
		zpad_d    = zpad_q;
		fw_d      = fw_q;
		sz_d      = sz_q;
		job_valid = 1'b0;
		job       = '0;
		job.kind  = JK_ECHO;
		job.ch    = b;
		if (accept) begin
			if (item.mode) begin
				job_valid = 1'b1;
			end else if (st_q == ST_PLAIN) begin
				if (b == CH_PCT) begin
					st_d   = ST_PERCENT;
					zpad_d = 1'b0;
					fw_d   = '0;
					sz_d   = SZ_NORMAL;
				end else begin
					job_valid = 1'b1;
				end
			end else if (st_q == ST_PERCENT && b == CH_PCT) begin
				st_d      = ST_PLAIN;
				job_valid = 1'b1;
			end else if (b >= CH_ZERO && b <= CH_NINE && st_q != ST_SIZE) begin
				if (st_q == ST_PERCENT) begin
					if (dig == 4'd0 && !zpad_q) begin
						zpad_d = 1'b1;
					end else begin
						st_d = ST_WIDTH;
						fw_d = FW_W'(dig);
					end
				end else begin
					fw_d = (wsum > (FW_W+4)'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH)
						: FW_W'(wsum);
				end
			end else if (b == CH_H || b == CH_L) begin
				if (st_q == ST_WIDTH)
					st_d = ST_SIZE;
				if (b == CH_H)
					sz_d = (sz_q == SZ_H) ? SZ_HH : SZ_H;
				else
					sz_d = (sz_q == SZ_L) ? SZ_LL : SZ_L;
			end else if (b == CH_D || b == CH_I || b == CH_X || b == CH_UX
					|| b == CH_C || b == CH_S) begin
				st_d = ST_PLAIN;
				if (b == CH_C) begin
					job_valid = 1'b1;
					job.kind  = JK_CHAR;
					job.ch    = item.arg_value[7:0];
					job.width = (fw_q == '0) ? '0 : fw_q - FW_W'(1);
				end else if (b == CH_S) begin
					job_valid = (item.arg_value < ARG_W'(fw_q));
					job.kind  = JK_PAD;
					job.width = fw_q - item.arg_value[FW_W-1:0];
				end else if (b == CH_D || b == CH_I) begin
					job_valid = 1'b1;
					job.kind  = JK_DEC;
					job.zpad  = zpad_q;
					job.width = fw_q;
					job.neg   = sbit;
					job.value = sbit ? ((~mag + 64'd1) & mask) : mag;
				end else begin
					job_valid = 1'b1;
					job.kind  = JK_HEX;
					job.zpad  = zpad_q;
					job.width = fw_q;
					job.upper = (b == CH_UX);
					job.value = mag;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_PLAIN;
			zpad_q <= 1'b0;
			fw_q   <= '0;
			sz_q   <= SZ_NORMAL;
		end else begin
			st_q   <= st_d;
			zpad_q <= zpad_d;
			fw_q   <= fw_d;
			sz_q   <= sz_d;
		end
	end
endmodule

// ===== rtl/pfe_back.sv =====
// formatter: converts numbers to digits and emits one character per beat
module pfe_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_avail,
	input  pfe_pkg::job_t    job,
	output logic             job_take,
	input  logic             pop,
	output logic             res_valid,
	output pfe_pkg::result_t result
);
	import pfe_pkg::*;

	back_state_t          bs_q, bs_d;
	logic [ARG_W-1:0]     bin_q, bin_d;
	logic [4*NUM_DEC-1:0] bcd_q, bcd_d, adj;
	logic [6:0]           cnt_q, cnt_d;
	logic [4:0]           ndig_q, ndig_d;
	logic [FW_W-1:0]      pad_q, pad_d, width_q, width_d;
	logic                 neg_q, neg_d, lit_q, lit_d, upper_q, upper_d, zpad_q, zpad_d;
	logic [7:0]           litch_q, litch_d;
	logic                 ov_q, ov_d;
	result_t              od_q, od_d;

	logic [4:0]      idx;
	logic [3:0]      top;
	logic [FW_W-1:0] tlen;
	logic            can_out;

	assign idx     = ndig_q - 5'd1;
	assign top     = bcd_q[idx*4 +: 4];
	assign tlen    = FW_W'(ndig_q) + FW_W'(neg_q);
	assign can_out = !ov_q || pop;
	assign job_take  = (bs_q == BK_IDLE) && job_avail;
	assign res_valid = ov_q;
	assign result    = od_q;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NUM_DEC; i++) begin
			adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
				: bcd_q[i*4 +: 4];
		end
	end

	always_comb begin
		bs_d    = bs_q;
		bin_d   = bin_q;
		bcd_d   = bcd_q;
		cnt_d   = cnt_q;
		ndig_d  = ndig_q;
		pad_d   = pad_q;
		width_d = width_q;
		neg_d   = neg_q;
		lit_d   = lit_q;
		upper_d = upper_q;
		zpad_d  = zpad_q;
		litch_d = litch_q;
		ov_d    = ov_q;
		od_d    = od_q;
		if (pop && ov_q)
			ov_d = 1'b0;
		unique case (bs_q)
			BK_IDLE: begin
				if (job_avail) begin
					width_d = job.width;
					neg_d   = job.neg;
					upper_d = job.upper;
					zpad_d  = job.zpad;
					litch_d = job.ch;
					pad_d   = '0;
					ndig_d  = '0;
					lit_d   = 1'b0;
					unique case (job.kind)
						JK_ECHO: begin
							lit_d = 1'b1;
							bs_d  = BK_EMIT;
						end
						JK_PAD: begin
							pad_d = job.width;
							bs_d  = BK_EMIT;
						end
						JK_CHAR: begin
							pad_d = job.width;
							lit_d = 1'b1;
							bs_d  = BK_EMIT;
						end
						JK_DEC: begin
							bin_d = job.value;
							bcd_d = '0;
							cnt_d = 7'(ARG_W);
							bs_d  = BK_CONV;
						end
						default: begin
							bcd_d  = (4*NUM_DEC)'(job.value);
							ndig_d = 5'(NUM_HEX);
							bs_d   = BK_STRIP;
						end
					endcase
				end
			end
			BK_CONV: begin
				bcd_d = {adj[4*NUM_DEC-2:0], bin_q[ARG_W-1]};
				bin_d = {bin_q[ARG_W-2:0], 1'b0};
				cnt_d = cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					ndig_d = 5'(NUM_DEC);
					bs_d   = BK_STRIP;
				end
			end
			BK_STRIP: begin
				if (ndig_q > 5'd1 && top == 4'd0) begin
					ndig_d = ndig_q - 5'd1;
				end else begin
					pad_d = (width_q > tlen) ? width_q - tlen : '0;
					bs_d  = BK_EMIT;
				end
			end
			default: begin
				if (can_out) begin
					ov_d = 1'b1;
					if (pad_q != '0) begin
						od_d.out_char = zpad_q ? CH_ZERO : CH_SPACE;
						od_d.last = (pad_q == FW_W'(1)) && !neg_q && ndig_q == '0 && !lit_q;
						pad_d = pad_q - FW_W'(1);
					end else if (neg_q) begin
						od_d.out_char = CH_MINUS;
						od_d.last = (ndig_q == '0) && !lit_q;
						neg_d = 1'b0;
					end else if (ndig_q != '0) begin
						od_d.out_char = digit_char(top, upper_q);
						od_d.last = (ndig_q == 5'd1) && !lit_q;
						ndig_d = ndig_q - 5'd1;
					end else begin
						od_d.out_char = litch_q;
						od_d.last = 1'b1;
						lit_d = 1'b0;
					end
					if (od_d.last)
						bs_d = BK_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		bin_q   <= bin_d;
		bcd_q   <= bcd_d;
		cnt_q   <= cnt_d;
		ndig_q  <= ndig_d;
		pad_q   <= pad_d;
		width_q <= width_d;
		neg_q   <= neg_d;
		lit_q   <= lit_d;
		upper_q <= upper_d;
		zpad_q  <= zpad_d;
		litch_q <= litch_d;
		od_q    <= od_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q <= BK_IDLE;
			ov_q <= 1'b0;
		end else begin
			bs_q <= bs_d;
			ov_q <= ov_d;
		end
	end
endmodule

// ===== bench/printf_format_engine_checker.sv =====
// checker of the printf format engine: predicts the emitted characters and compares beats
`timescale 1ns / 100ps

module printf_format_engine_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             full,
	input  pfe_pkg::item_t   item,
	input  logic             pop,
	input  logic             empty,
	input  pfe_pkg::result_t result,
	output int               fail_count,
	output int               pending
);
	import pfe_pkg::*;

	parse_state_t pstate;
	logic         zpad;
	logic         upper;
	int           fwidth;
	size_code_t   szc;
	result_t      expected_chars[$];

	assign pending = expected_chars.size();

	function automatic logic [63:0] size_mask(input size_code_t s);
		case (s)
			SZ_HH: return 64'hFF;
			SZ_H: return 64'hFFFF;
			SZ_L, SZ_LL: return '1;
			default: return 64'hFFFF_FFFF;
		endcase
	endfunction

	task automatic add_char(input logic [7:0] c, inout result_t q[$]);
		result_t r;
		r.out_char = c;
		r.last = 1'b0;
		q.push_back(r);
	endtask

	task automatic format_spec(input logic [7:0] b, input logic [63:0] arg, inout result_t q[$]);
		logic [7:0]  txt[$];
		logic [63:0] mask, mag, sbit;
		logic        neg;
		int          w, d;
		pstate = ST_PLAIN;
		if (b == CH_C) begin
			w = (fwidth == 0) ? 1 : fwidth;
			for (int i = 1; i < w; i++) add_char(CH_SPACE, q);
			add_char(arg[7:0], q);
			return;
		end
		if (b == CH_S) begin
			for (longint unsigned i = 0; i + arg < 64'(fwidth); i++) add_char(CH_SPACE, q);
			return;
		end
		mask = size_mask(szc);
		mag = arg & mask;
		neg = 1'b0;
		if (b == CH_D || b == CH_I) begin
			sbit = (mask >> 1) + 64'd1;
			if ((mag & sbit) != 0) begin
				neg = 1'b1;
				mag = (64'd0 - mag) & mask;
				if (mag == 0) mag = sbit;
			end
			do begin
				txt.push_front(CH_ZERO + 8'(mag % 10));
				mag = mag / 10;
			end while (mag != 0);
		end else begin
			if (b == CH_UX) upper = 1'b1;
			do begin
				d = int'(mag[3:0]);
				txt.push_front(d < 10 ? CH_ZERO + 8'(d) : (upper ? CH_UA : CH_LA) + 8'(d - 10));
				mag = mag >> 4;
			end while (mag != 0);
		end
		if (neg) txt.push_front(CH_MINUS);
		for (int i = txt.size(); i < fwidth; i++) add_char(zpad ? CH_ZERO : CH_SPACE, q);
		foreach (txt[i]) add_char(txt[i], q);
	endtask

	task automatic predict_item(input item_t it);
		result_t     q[$];
		logic [7:0]  b;
		int          w;
		b = it.in_byte;
		if (it.mode) begin
			add_char(b, q);
		end else if (pstate == ST_PLAIN) begin
			if (b == CH_PCT) begin
				pstate = ST_PERCENT;
				zpad = 0;
				upper = 0;
				fwidth = 0;
				szc = SZ_NORMAL;
			end else begin
				add_char(b, q);
			end
		end else if (pstate == ST_PERCENT && b == CH_PCT) begin
			pstate = ST_PLAIN;
			add_char(b, q);
		end else if (b >= CH_ZERO && b <= CH_NINE && pstate != ST_SIZE) begin
			if (pstate == ST_PERCENT) begin
				if (b == CH_ZERO && !zpad) begin
					zpad = 1;
				end else begin
					pstate = ST_WIDTH;
					fwidth = int'(b - CH_ZERO);
				end
			end else begin
				w = 10 * fwidth + int'(b - CH_ZERO);
				fwidth = w > MAX_WIDTH ? MAX_WIDTH : w;
			end
		end else if (b == CH_H || b == CH_L) begin
			if (pstate == ST_WIDTH) pstate = ST_SIZE;
			if (b == CH_H) szc = (szc == SZ_H) ? SZ_HH : SZ_H;
			else szc = (szc == SZ_L) ? SZ_LL : SZ_L;
		end else if (b == CH_D || b == CH_I || b == CH_X || b == CH_UX || b == CH_C || b == CH_S) begin
			format_spec(b, it.arg_value, q);
		end
		if (q.size() > 0) q[q.size() - 1].last = 1'b1;
		foreach (q[i]) expected_chars.push_back(q[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			pstate = ST_PLAIN;
			zpad = 0;
			upper = 0;
			fwidth = 0;
			szc = SZ_NORMAL;
			fail_count = 0;
			expected_chars.delete();
		end else begin
			if (push && !full) predict_item(item);
			if (pop && !empty) begin
				if (expected_chars.size() == 0) begin
					$error("unexpected beat: out_char %h last %b", result.out_char, result.last);
					fail_count++;
				end else begin
					e = expected_chars.pop_front();
					if (result.out_char !== e.out_char) begin
						$error("out_char: expected %h, actual %h", e.out_char, result.out_char);
						fail_count++;
					end
					if (result.last !== e.last) begin
						$error("last: expected %b, actual %b", e.last, result.last);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

// ===== bench/printf_format_engine_core_tb.sv =====
// testbench top of the printf format engine: stimulus, handshakes and verdict
`timescale 1ns / 100ps

module printf_format_engine_core_tb;
	import pfe_pkg::*;

	logic    clk;
	logic    arst_n;
	logic    push;
	logic    full;
	item_t   item;
	logic    pop;
	logic    empty;
	result_t result;
	int      fail_count;
	int      pending;
	bit      sending;

	printf_format_engine_core DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.pop(pop), .empty(empty), .result(result)
	);

	printf_format_engine_checker checker_i (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.pop(pop), .empty(empty), .result(result), .fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [63:0] rand_arg();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: v = 0;
			1: v = '1;
			2: v = 64'h8000_0000_0000_0000;
			3: v = 64'(v[7:0]);
			default: ;
		endcase
		return v;
	endfunction

	// one beat; push stays high between back-to-back items
	task automatic send(input logic m, input logic [7:0] b, input logic [63:0] a);
		int g;
		g = gap_len();
		if (g > 0) begin
			push <= 0;
			repeat (g) @(negedge clk);
		end
		push <= 1;
		item <= '{mode: m, in_byte: b, arg_value: a};
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic send_str(input string s);
		foreach (s[i]) send(0, s[i], rand_arg());
	endtask

	task automatic rand_spec();
		logic [7:0] specs[6];
		logic [7:0] sp;
		int         slen;
		specs = '{CH_D, CH_I, CH_X, CH_UX, CH_C, CH_S};
		send(0, CH_PCT, 0);
		if ($urandom_range(0, 2) == 0) send(0, CH_ZERO, 0);
		if ($urandom_range(0, 1)) send(0, 8'($urandom_range(CH_ZERO + 1, CH_NINE)), 0);
		if ($urandom_range(0, 2) == 0) send(0, 8'($urandom_range(CH_ZERO, CH_NINE)), 0);
		case ($urandom_range(0, 4))
			0: send(0, CH_H, 0);
			1: begin send(0, CH_H, 0); send(0, CH_H, 0); end
			2: send(0, CH_L, 0);
			3: begin send(0, CH_L, 0); send(0, CH_L, 0); end
			default: ;
		endcase
		if ($urandom_range(0, 9) == 0) send(0, 8'($urandom), rand_arg());
		sp = specs[$urandom_range(0, 5)];
		if (sp == CH_S) begin
			slen = $urandom_range(0, 6);
			send(0, CH_S, 64'(slen));
			repeat (slen) send(1, 8'($urandom), rand_arg());
		end else begin
			send(0, sp, rand_arg());
		end
	endtask

	initial begin
		int n;
		push = 0;
		pop = 0;
		item = '0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		sending = 1;
		// directed: echo, %%, extremes, sizes, padding, saturation
		send(0, 8'h00, 0);
		send(0, 8'hFF, '1);
		send_str("%%");
		send_str("%05d");
		send(0, CH_D, 64'hFFFF_FFFF);
		send_str("%hh");
		send(0, CH_I, 64'h80);
		send_str("%99l");
		send(0, CH_UX, '1);
		send_str("%00c");
		send(0, CH_C, 64'h41);
		send_str("%3s");
		send(1, 8'hAA, 0);
		send(0, CH_X, 0);
		send(0, CH_S, 64'hFFFF_FFFF_FFFF_FFFF);
		// a random spec averages about five beats
		n = 0;
		while (n < 70) begin
			if ($urandom_range(0, 3) == 0) begin
				send(0, 8'($urandom), rand_arg());
				n++;
			end else begin
				rand_spec();
				n += 5;
			end
		end
		push <= 0;
		sending = 0;
	end

	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			pop <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
			if ($urandom_range(0, 30) == 0) begin
				pop <= 0;
				repeat ($urandom_range(5, 40)) @(negedge clk);
			end
		end
	end

	initial begin
		wait (arst_n);
		@(negedge clk);
		wait (!sending);
		wait (pending == 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/pfe_pkg.sv
rtl/pfe_fifo.sv
rtl/pfe_front.sv
rtl/pfe_back.sv
rtl/printf_format_engine_core.sv
bench/printf_format_engine_checker.sv
bench/printf_format_engine_core_tb.sv
